>>> hw/rtl/cmbpd_pkg.sv
// Shared types and constants of the cross-median bad pixel detector.
`default_nettype none

package cmbpd_pkg;

   // Field widths
   localparam int PIXEL_BITS     = 16;
   localparam int SIZE_BITS      = 13;
   localparam int THRESHOLD_BITS = 16;
   localparam int POS_BITS       = 12;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_THRESHOLD    = 2'd2
   } csr_index_type;

   // Register reset values
   localparam logic [SIZE_BITS-1:0]      FRAME_WIDTH_RESET  = 13'd4096;
   localparam logic [SIZE_BITS-1:0]      FRAME_HEIGHT_RESET = 13'd4096;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET    = 16'hFFFF;

   // Result kinds
   localparam logic KIND_HOT  = 1'b0;
   localparam logic KIND_DARK = 1'b1;

   // Number of values in the cross neighborhood
   localparam int CROSS_SIZE = 5;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

endpackage

`default_nettype wire

>>> hw/rtl/cmbpd_if.sv
// Valid/ready channel interfaces for pixel input and flagged-pixel output.
`default_nettype none

interface cmbpd_req_if;
   import cmbpd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface cmbpd_rsp_if;
   import cmbpd_pkg::*;

   logic                valid;
   logic                ready;
   logic [POS_BITS-1:0] column;
   logic [POS_BITS-1:0] row;
   logic                kind;

   modport source (output valid, output column, output row, output kind, input ready);
   modport sink   (input valid, input column, input row, input kind, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cross_median_bad_pixel_detector.sv
// Top level of the cross-median bad pixel detector: column buffers, median and compare.
// Throughput: one pixel per cycle while no flagged result waits at the output; the two
//   column memories are read and written in the cycle a pixel transaction is accepted.
// Latency: a flagged pixel reaches rsp after the transaction of its right neighbor is accepted,
//   through the memory read, median select, difference and compare registers, in that order.
// Reset: counters, bank select and valids clear, the CSRs take their reset values; the
//   column memories are not cleared, and a tested pixel uses no entry unwritten in a frame.
`default_nettype none

module cross_median_bad_pixel_detector #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                                        clock,
   input  wire                                        reset,
   cmbpd_req_if.sink                                  req_ch,
   cmbpd_rsp_if.source                                rsp_ch,
   input  wire                                        csr_we,
   input  wire  [cmbpd_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire  [cmbpd_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import cmbpd_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = $clog2(MAX_HEIGHT);
   localparam logic [31:0] MAX_WIDTH_W  = 32'(MAX_WIDTH);
   localparam logic [31:0] MAX_HEIGHT_W = 32'(MAX_HEIGHT);

   // Configuration registers
   logic [SIZE_BITS-1:0]      width_ff;
   logic [SIZE_BITS-1:0]      height_ff;
   logic [THRESHOLD_BITS-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= FRAME_WIDTH_RESET;
         height_ff    <= FRAME_HEIGHT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff     <= csr_wdata[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT: height_ff    <= csr_wdata[SIZE_BITS-1:0];
            CSR_THRESHOLD:    threshold_ff <= csr_wdata[THRESHOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame size in use, clamped to the supported range
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;

   always_comb begin
      if (width_ff < SIZE_BITS'(3))              w_eff = CW'(3);
      else if (32'(width_ff) > MAX_WIDTH_W)      w_eff = CW'(MAX_WIDTH);
      else                                       w_eff = CW'(width_ff);
      if (height_ff < SIZE_BITS'(3))             h_eff = RW'(3);
      else if (32'(height_ff) > MAX_HEIGHT_W)    h_eff = RW'(MAX_HEIGHT);
      else                                       h_eff = RW'(height_ff);
   end

   // Handshake: the whole pipeline moves unless a result waits at the output and is not taken
   logic rsp_valid_ff;
   logic advance;
   logic req_accept;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign req_accept   = req_ch.valid && advance;

   // Position counters and column bank select
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] c_cur, c_next;
   logic [RW-1:0] r_cur, r_next;
   logic          test_cur;

   always_comb begin
      c_cur = req_ch.frame_start ? '0 : col_ff;
      r_cur = req_ch.frame_start ? '0 : row_ff;
      if (r_cur >= h_eff) begin
         r_cur = '0;
         c_cur = c_cur + 1'b1;
      end
      if (c_cur >= w_eff) begin
         c_cur = '0;
      end
      test_cur = (c_cur >= CW'(2)) && (c_cur <= w_eff - 1'b1) &&
                 (r_cur >= RW'(1)) && (r_cur <= h_eff - RW'(2));
      r_next  = r_cur + 1'b1;
      c_next  = c_cur + 1'b1;
      bank_in = bank_ff;
      if (r_next >= h_eff) begin
         // column done: the newer column becomes the older one
         row_in  = '0;
         col_in  = (c_next >= w_eff) ? '0 : c_next;
         bank_in = !bank_ff;
      end else begin
         row_in = r_next;
         col_in = c_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         bank_ff <= 1'b0;
      end else if (req_accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         bank_ff <= bank_in;
      end
   end

   // Column memories; bank 0 means memory A holds the older column
   logic [AW-1:0] addr_cur, addr_below;
   logic [RW-1:0] r_below;

   assign r_below    = r_cur + 1'b1;
   assign addr_cur   = r_cur[AW-1:0];
   assign addr_below = r_below[AW-1:0];

   pixel_type mem_a [MAX_HEIGHT];
   pixel_type mem_b [MAX_HEIGHT];
   pixel_type a_rd0_ff, a_rd1_ff, b_rd0_ff, b_rd1_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_rd0_ff <= mem_a[addr_cur];
         a_rd1_ff <= mem_a[addr_below];
         if (!bank_ff) begin
            mem_a[addr_cur] <= req_ch.pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_rd0_ff <= mem_b[addr_cur];
         b_rd1_ff <= mem_b[addr_below];
         if (bank_ff) begin
            mem_b[addr_cur] <= req_ch.pixel;
         end
      end
   end

   // Stage 1: item that owns the memory read data
   logic          s1_valid_ff;
   pixel_type     s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          s1_bank_ff;
   pixel_type     up_ff;
   pixel_type     older_val, newer_val, below_val;

   assign older_val = s1_bank_ff ? b_rd0_ff : a_rd0_ff;
   assign newer_val = s1_bank_ff ? a_rd0_ff : b_rd0_ff;
   assign below_val = s1_bank_ff ? a_rd1_ff : b_rd1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept && test_cur;
      end
   end

   // the previous transaction's center read is the upper neighbor of this one
   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_ff      <= newer_val;
         s1_pix_ff  <= req_ch.pixel;
         s1_col_ff  <= c_cur - 1'b1;
         s1_row_ff  <= r_cur;
         s1_bank_ff <= bank_ff;
      end
   end

   // Stage 2: rank each value of the cross, mark the median
   pixel_type             cross_val [CROSS_SIZE];
   logic [CROSS_SIZE-1:0] med_sel_in;

   assign cross_val[0] = older_val;
   assign cross_val[1] = newer_val;
   assign cross_val[2] = s1_pix_ff;
   assign cross_val[3] = up_ff;
   assign cross_val[4] = below_val;

   always_comb begin
      logic [2:0] rank;
      for (int i = 0; i < CROSS_SIZE; i++) begin
         rank = '0;
         for (int j = 0; j < CROSS_SIZE; j++) begin
            // ties are broken by position so exactly one value gets each rank
            if (j < i && cross_val[j] <= cross_val[i]) rank = rank + 1'b1;
            if (j > i && cross_val[j] <  cross_val[i]) rank = rank + 1'b1;
         end
         med_sel_in[i] = (rank == 3'd2);
      end
   end

   logic                  s2_valid_ff;
   pixel_type             s2_val_ff [CROSS_SIZE];
   logic [CROSS_SIZE-1:0] s2_sel_ff;
   logic [CW-1:0]         s2_col_ff;
   logic [RW-1:0]         s2_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_val_ff <= cross_val;
         s2_sel_ff <= med_sel_in;
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
      end
   end

   // Stage 3: center minus median
   pixel_type               median_val;
   logic signed [PIXEL_BITS:0] diff_in;

   always_comb begin
      median_val = '0;
      for (int i = 0; i < CROSS_SIZE; i++) begin
         median_val = median_val | (s2_val_ff[i] & {PIXEL_BITS{s2_sel_ff[i]}});
      end
      diff_in = $signed({1'b0, s2_val_ff[1]}) - $signed({1'b0, median_val});
   end

   logic                       s3_valid_ff;
   logic signed [PIXEL_BITS:0] s3_diff_ff;
   logic [CW-1:0]              s3_col_ff;
   logic [RW-1:0]              s3_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_diff_ff <= diff_in;
         s3_col_ff  <= s2_col_ff;
         s3_row_ff  <= s2_row_ff;
      end
   end

   // Output stage: compare against the threshold band
   logic signed [PIXEL_BITS+1:0] diff_ext, thr_pos, thr_neg;
   logic                         is_hot, is_dark;

   assign diff_ext = {s3_diff_ff[PIXEL_BITS], s3_diff_ff};
   assign thr_pos  = $signed({2'b00, threshold_ff});
   assign thr_neg  = -thr_pos;
   assign is_hot   = diff_ext > thr_pos;
   assign is_dark  = diff_ext < thr_neg;

   logic [POS_BITS-1:0] rsp_col_ff, rsp_row_ff;
   logic                rsp_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff && (is_hot || is_dark);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_col_ff  <= POS_BITS'(s3_col_ff);
         rsp_row_ff  <= POS_BITS'(s3_row_ff);
         rsp_kind_ff <= is_hot ? KIND_HOT : KIND_DARK;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.column = rsp_col_ff;
   assign rsp_ch.row    = rsp_row_ff;
   assign rsp_ch.kind   = rsp_kind_ff;

   // Checks
   a_stall_only_on_held_result: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a held result");

   a_bank_moves_on_accept: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> $past(req_accept))
      else $error("column bank swapped without a transaction");

   a_tested_row_interior: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (s1_row_ff != '0))
      else $error("top border row entered the test pipeline");

   a_result_from_tested_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s3_valid_ff))
      else $error("result appeared without a tested pixel");

   a_single_median: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $onehot(s2_sel_ff))
      else $error("median select is not one-hot");

endmodule

`default_nettype wire
